[src/sst_pkg.sv]
// Package for the speech segment tracker: word types, register codes, constants.
// Depends on nothing; every other file in src but sst_queue imports it.
package sst_pkg;

	// Fixed field widths and sizes
	localparam int PROB_BITS      = 10;
	localparam int OUT_BITS       = 31;
	localparam int WIN_BITS       = 13;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 32;
	localparam int COUNT_BITS_DEF = 32;
	localparam int QUEUE_DEPTH    = 2;

	// 0.15 in Q0.PROB_BITS, rounded to nearest
	localparam int NEAR_OFFSET_I = ((15 << PROB_BITS) + 50) / 100;
	localparam logic [PROB_BITS:0] NEAR_OFFSET = (PROB_BITS + 1)'(NEAR_OFFSET_I);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_THRESHOLD   = 3'd0,
		REG_WINDOW      = 3'd1,
		REG_MIN_SILENCE = 3'd2,
		REG_MIN_SPEECH  = 3'd3,
		REG_MAX_SPEECH  = 3'd4,
		REG_SPLIT_SIL   = 3'd5
	} reg_idx_t;

	// Register file contents
	typedef struct packed {
		logic [PROB_BITS-1:0] speech_threshold;
		logic [WIN_BITS-1:0]  window_samples;
		logic [31:0]          min_quiet_len;
		logic [30:0]          min_talk_len;
		logic [31:0]          max_talk_len;
		logic [31:0]          split_silence_samples;
	} cfg_t;

	// Input word
	typedef struct packed {
		logic                 func;
		logic [PROB_BITS-1:0] speech_prob;
		logic [OUT_BITS-1:0]  total_samples;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic [OUT_BITS-1:0] seg_start;
		logic [OUT_BITS-1:0] seg_end;
	} out_word_t;

	// Classified command between front and back
	typedef struct packed {
		logic                finish;
		logic                speech;
		logic                silence;
		logic [OUT_BITS-1:0] total_samples;
	} cmd_t;

endpackage

[src/speech_segment_tracker.sv]
// Top level of the speech segment tracker: register file, classifier front end,
// command queue, segment back end and result queue. Depends on sst_pkg and all sst_ modules.
//
//   channel  | handshake              | word
//   ---------+------------------------+---------------------------------------
//   input    | push / full            | item   : func, speech_prob, total_samples
//   result   | pop / empty            | result : seg_start, seg_end
//   config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word per cycle sustained while full is low; a word passes the command queue register
// to the back end, and its segment, if any, the result queue register to the result port.
// The back end retires one command per cycle, stalling only when the result queue is full.
// Reset clears all queues and tracking state; config returns to default values.
// A stalled result side fills the two-entry result queue, then the command queue, then full rises.
module speech_segment_tracker #(
	parameter int COUNT_BITS = sst_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  sst_pkg::in_word_t                 item,
	output logic                              empty,
	input  logic                              pop,
	output sst_pkg::out_word_t                result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sst_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [sst_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import sst_pkg::*;

	cfg_t      cfg;
	cmd_t      cmd_in, cmd_head;
	out_word_t res_word;
	logic      cmd_empty, cmd_pop, res_full, res_push;

	// configuration registers
	sst_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// classify incoming words
	sst_front u_front (
		.item             (item),
		.speech_threshold (cfg.speech_threshold),
		.cmd              (cmd_in)
	);

	// command queue between front and back
	sst_queue #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	// segment tracking
	sst_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_word)
	);

	// result queue
	sst_queue #(
		.WIDTH ($bits(out_word_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_word),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

[src/sst_regs.sv]
// Configuration register file of the speech segment tracker.
// Depends on sst_pkg.
module sst_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sst_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [sst_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output sst_pkg::cfg_t                       cfg
);
	import sst_pkg::*;

	cfg_t cfg_q;

	// always able to take a write
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speech_threshold      <= PROB_BITS'(512);
			cfg_q.window_samples        <= WIN_BITS'(512);
			cfg_q.min_quiet_len         <= 32'd1600;
			cfg_q.min_talk_len          <= 31'd4000;
			cfg_q.max_talk_len          <= 32'hFFFF_FFFF;
			cfg_q.split_silence_samples <= 32'd1568;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_THRESHOLD:   cfg_q.speech_threshold      <= cfg_data[PROB_BITS-1:0];
				REG_WINDOW:      cfg_q.window_samples        <= cfg_data[WIN_BITS-1:0];
				REG_MIN_SILENCE: cfg_q.min_quiet_len         <= cfg_data[31:0];
				REG_MIN_SPEECH:  cfg_q.min_talk_len          <= cfg_data[30:0];
				REG_MAX_SPEECH:  cfg_q.max_talk_len          <= cfg_data[31:0];
				REG_SPLIT_SIL:   cfg_q.split_silence_samples <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

endmodule

[src/sst_queue.sv]
// Small first-in first-out queue of WIDTH-bit words, used between stages.
// Depends on nothing beyond its parameters.
module sst_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == (AW + 1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
		end
	end

endmodule

[src/sst_front.sv]
// Front end: classifies each input word into finish / speech / silence / near.
// Depends on sst_pkg.
module sst_front (
	input  sst_pkg::in_word_t                item,
	input  logic [sst_pkg::PROB_BITS-1:0]    speech_threshold,
	output sst_pkg::cmd_t                    cmd
);
	import sst_pkg::*;

	logic                 is_speech;
	logic [PROB_BITS:0]   prob_plus_near;

	// speech band: prob at or above threshold
	assign is_speech      = (item.speech_prob >= speech_threshold);
	// silence band: prob below threshold minus the near offset
	assign prob_plus_near = {1'b0, item.speech_prob} + NEAR_OFFSET;

	always_comb begin
		cmd.finish        = item.func;
		cmd.speech        = is_speech;
		cmd.silence       = !is_speech && (prob_plus_near < {1'b0, speech_threshold});
		cmd.total_samples = item.total_samples;
	end

endmodule

[src/sst_back.sv]
// Back end: segment state machine, one command per cycle unless the result queue
// is full; emits closed segments. Depends on sst_pkg.
module sst_back #(
	parameter int COUNT_BITS = sst_pkg::COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sst_pkg::cfg_t      cfg,
	input  sst_pkg::cmd_t      cmd,
	input  logic               cmd_empty,
	output logic               cmd_pop,
	input  logic               res_full,
	output logic               res_push,
	output sst_pkg::out_word_t res
);
	import sst_pkg::*;

	localparam int C  = COUNT_BITS;
	localparam int CW = (C > 32) ? C : 32;        // compare width
	localparam int WW = (C > OUT_BITS) ? C : OUT_BITS;

	logic [C-1:0] pos_q, open_q, sil_q, split_q, resume_q;
	logic         in_speech_q;

	logic [C-1:0] pos_n, open_n, sil_n, split_n, resume_n;
	logic         in_speech_n;
	logic [C-1:0] len, sb, d_sil, d_seg;
	logic [C-1:0] emit_start, emit_end;
	logic         emit, fire, resume_lt_split;
	logic [WW-1:0] start_w, end_w;

	// take a command only when a possible result has room
	assign fire    = !cmd_empty && !res_full;
	assign cmd_pop = fire;

	assign resume_lt_split = ($signed(resume_q) < $signed(split_q));
	assign pos_n  = pos_q + C'(cfg.window_samples);
	assign len    = pos_n - open_q;
	assign sb     = (sil_q == '0) ? pos_n : sil_q;
	assign d_sil  = pos_n - sb;
	assign d_seg  = sb - open_q;

	// next state
	always_comb begin
		open_n      = open_q;
		sil_n       = sil_q;
		split_n     = split_q;
		resume_n    = resume_q;
		in_speech_n = in_speech_q;
		emit        = 1'b0;
		emit_start  = open_q;
		emit_end    = pos_n;
		if (cmd.finish) begin
			// flush: emit any open segment, clear everything
			emit        = !open_q[C-1];
			open_n      = '1;
			sil_n       = '0;
			split_n     = '0;
			resume_n    = '0;
			in_speech_n = 1'b0;
		end else if (cmd.speech) begin
			// speech cancels pending silence and opens a segment
			if (sil_q != '0) begin
				sil_n = '0;
				if (resume_lt_split) begin
					resume_n = pos_q;
				end
			end
			if (!in_speech_q) begin
				in_speech_n = 1'b1;
				open_n      = pos_q;
			end
		end else if (in_speech_q && (CW'(len) > CW'(cfg.max_talk_len))) begin
			// overlong segment: split at last pause or cut here
			emit = 1'b1;
			if (!split_q[C-1] && (split_q != '0)) begin
				emit_end = split_q;
				if (resume_lt_split) begin
					in_speech_n = 1'b0;
					open_n      = '1;
				end else begin
					open_n = resume_q;
				end
			end else begin
				open_n      = '1;
				in_speech_n = 1'b0;
			end
			split_n  = '0;
			resume_n = '0;
			sil_n    = '0;
		end else if (cmd.silence && in_speech_q) begin
			// silence: track its start, mark split points, maybe close
			sil_n = sb;
			if (CW'(d_sil) > CW'(cfg.split_silence_samples)) begin
				split_n = sb;
			end
			if ((CW'(d_sil) >= CW'(cfg.min_quiet_len)) && !d_seg[C-1]
					&& (CW'(d_seg) > CW'(cfg.min_talk_len))) begin
				emit        = 1'b1;
				emit_end    = sb;
				open_n      = '1;
				sil_n       = '0;
				split_n     = '0;
				resume_n    = '0;
				in_speech_n = 1'b0;
			end
		end
	end

	// result word, masked to output width
	assign start_w  = WW'(emit_start);
	assign end_w    = WW'(emit_end);
	assign res_push = fire && emit;
	always_comb begin
		res.seg_start = start_w[OUT_BITS-1:0];
		res.seg_end   = cmd.finish ? (cmd.total_samples - OUT_BITS'(1)) : end_w[OUT_BITS-1:0];
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			open_q      <= '1;
			sil_q       <= '0;
			split_q     <= '0;
			resume_q    <= '0;
			in_speech_q <= 1'b0;
		end else if (fire) begin
			pos_q       <= cmd.finish ? '0 : pos_n;
			open_q      <= open_n;
			sil_q       <= sil_n;
			split_q     <= split_n;
			resume_q    <= resume_n;
			in_speech_q <= in_speech_n;
		end
	end

endmodule

[test/sst_tb_pkg.sv]
`timescale 1ns / 1ps
// Shared test constants for the speech segment tracker bench: item function codes
// and band limits. Depends on sst_pkg for the probability width.
package sst_tb_pkg;

	// Item function codes
	localparam logic FUNC_WINDOW = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;

	// Width of the near band below the threshold (0.15, rounded to nearest)
	localparam int NEAR_BAND = ((15 << sst_pkg::PROB_BITS) + 50) / 100;
	localparam int PROB_MAX  = (1 << sst_pkg::PROB_BITS) - 1;

endpackage

[test/segment_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the speech segment tracker: mirrors register writes and segment
// tracking, and compares each popped segment. Depends on sst_pkg and sst_tb_pkg.
module segment_checker #(
	parameter int COUNT_BITS = sst_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic                              full,
	input  sst_pkg::in_word_t                 item,
	input  logic                              pop,
	input  logic                              empty,
	input  sst_pkg::out_word_t                result,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [sst_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [sst_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output int                                fail_count,
	output int                                pending
);
	import sst_pkg::*;
	import sst_tb_pkg::*;

	localparam int MAX_REPORTS = 10;

	// Mirrored registers and tracking state
	cfg_t                  settings;
	logic [COUNT_BITS-1:0] sample_pos;
	logic [COUNT_BITS-1:0] seg_open;
	logic [COUNT_BITS-1:0] quiet_from;
	logic [COUNT_BITS-1:0] split_at;
	logic [COUNT_BITS-1:0] resume_at;
	logic                  talking;

	out_word_t segment_q[$];
	out_word_t want;
	out_word_t seg;
	int        mismatches;

	function automatic bit less_signed(logic [COUNT_BITS-1:0] a, logic [COUNT_BITS-1:0] b);
		return $signed(a) < $signed(b);
	endfunction

	// No open segment, no pending silence or split point
	function automatic void drop_segment();
		seg_open   = '1;
		split_at   = '0;
		resume_at  = '0;
		quiet_from = '0;
		talking    = 1'b0;
	endfunction

	// Advance the tracker by one word; returns 1 when a segment closes
	function automatic bit track_word(input in_word_t w, output out_word_t closed);
		logic [COUNT_BITS-1:0] win;
		logic [COUNT_BITS-1:0] win_start;
		logic [COUNT_BITS-1:0] span;
		int                    floor_line;
		bit                    hit;
		closed = '0;
		win = COUNT_BITS'(settings.window_samples);

		// finish: flush the open segment up to the last sample
		if (w.func == FUNC_FINISH) begin
			hit = !seg_open[COUNT_BITS-1];
			closed.seg_start = OUT_BITS'(seg_open);
			closed.seg_end = w.total_samples - OUT_BITS'(1);
			sample_pos = '0;
			drop_segment();
			return hit;
		end

		sample_pos = sample_pos + win;
		win_start = sample_pos - win;

		// speech band
		if (w.speech_prob >= settings.speech_threshold) begin
			if (quiet_from != '0) begin
				quiet_from = '0;
				if (less_signed(resume_at, split_at))
					resume_at = win_start;
			end
			if (!talking) begin
				talking = 1'b1;
				seg_open = win_start;
			end
			return 1'b0;
		end

		// too long: split at the last long pause, or cut here
		span = sample_pos - seg_open;
		if (talking && 64'(span) > 64'(settings.max_talk_len)) begin
			closed.seg_start = OUT_BITS'(seg_open);
			if (less_signed('0, split_at)) begin
				closed.seg_end = OUT_BITS'(split_at);
				seg_open = '1;
				if (less_signed(resume_at, split_at))
					talking = 1'b0;
				else
					seg_open = resume_at;
				split_at   = '0;
				resume_at  = '0;
				quiet_from = '0;
			end else begin
				closed.seg_end = OUT_BITS'(sample_pos);
				drop_segment();
			end
			return 1'b1;
		end

		// near band, or silence with nothing open: no action
		floor_line = int'(settings.speech_threshold) - NEAR_BAND;
		if (int'(w.speech_prob) >= floor_line || !talking)
			return 1'b0;

		// silence band
		if (quiet_from == '0)
			quiet_from = sample_pos;
		span = sample_pos - quiet_from;
		if (64'(span) > 64'(settings.split_silence_samples))
			split_at = quiet_from;
		if (64'(span) < 64'(settings.min_quiet_len))
			return 1'b0;

		span = quiet_from - seg_open;
		if (!span[COUNT_BITS-1] && 64'(span) > 64'(settings.min_talk_len)) begin
			closed.seg_start = OUT_BITS'(seg_open);
			closed.seg_end = OUT_BITS'(quiet_from);
			drop_segment();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Watch all three channels; pops are checked before the new word is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings.speech_threshold      = PROB_BITS'(512);
			settings.window_samples        = WIN_BITS'(512);
			settings.min_quiet_len         = 32'd1600;
			settings.min_talk_len          = 31'd4000;
			settings.max_talk_len          = 32'hFFFF_FFFF;
			settings.split_silence_samples = 32'd1568;
			sample_pos = '0;
			drop_segment();
			segment_q.delete();
			mismatches = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_THRESHOLD:   settings.speech_threshold = cfg_data[PROB_BITS-1:0];
					REG_WINDOW:      settings.window_samples = cfg_data[WIN_BITS-1:0];
					REG_MIN_SILENCE: settings.min_quiet_len = cfg_data;
					REG_MIN_SPEECH:  settings.min_talk_len = cfg_data[30:0];
					REG_MAX_SPEECH:  settings.max_talk_len = cfg_data;
					REG_SPLIT_SIL:   settings.split_silence_samples = cfg_data;
					default: ;
				endcase
			end

			if (pop && !empty) begin
				if (segment_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: segment popped with none predicted: start %0d end %0d",
							$time, result.seg_start, result.seg_end);
				end else begin
					want = segment_q.pop_front();
					if (result.seg_start !== want.seg_start || result.seg_end !== want.seg_end) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: segment mismatch: expected %0d..%0d, got %0d..%0d",
								$time, want.seg_start, want.seg_end,
								result.seg_start, result.seg_end);
					end
				end
			end

			if (push && !full) begin
				if (track_word(item, seg))
					segment_q.insert(segment_q.size(), seg);
			end

			pending <= segment_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

[test/tb_speech_segment_tracker.sv]
`timescale 1ns / 1ps
// Testbench top for speech_segment_tracker: directed and random window/finish traffic
// under varying stalls and settings. Depends on sst_pkg, sst_tb_pkg and segment_checker.
module tb_speech_segment_tracker;
	import sst_pkg::*;
	import sst_tb_pkg::*;

	localparam int LIMIT_CYCLES   = 500000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int SEGMENT_ITEMS  = 140;
	localparam int CONFIG_ROUNDS  = 9;

	// Indexes that decode to no register
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 3'd7;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     push = 1'b0;
	logic                     full;
	in_word_t                 item = '0;
	logic                     empty;
	logic                     pop = 1'b0;
	out_word_t                result;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	int fail_count;
	int pending;
	int tx_idle = 17;
	int rx_idle = 87;
	int cycle_count;

	speech_segment_tracker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	segment_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.pop        (pop),
		.empty      (empty),
		.result     (result),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Result side: random pop stalls
	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= rx_idle);
	end

	// Send one word, idling first at the current rate; push stays high on return
	task automatic send_word(input in_word_t w);
		if ($urandom_range(99) < tx_idle) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle);
		end
		item <= w;
		push <= 1'b1;
		do @(posedge clk); while (full);
	endtask

	task automatic send_window(input logic [PROB_BITS-1:0] prob);
		in_word_t w;
		w.func = FUNC_WINDOW;
		w.speech_prob = prob;
		w.total_samples = OUT_BITS'($urandom);
		send_word(w);
	endtask

	task automatic send_finish(input logic [OUT_BITS-1:0] total);
		in_word_t w;
		w.func = FUNC_FINISH;
		w.speech_prob = PROB_BITS'($urandom);
		w.total_samples = total;
		send_word(w);
	endtask

	// Drain: every predicted segment popped, then let the pipeline empty
	task automatic settle();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write every register, junk above each narrower field, plus the unused indexes
	task automatic load_settings(input cfg_t c);
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_THRESHOLD, {22'($urandom), c.speech_threshold});
		write_reg(REG_WINDOW, {19'($urandom), c.window_samples});
		write_reg(REG_MIN_SILENCE, c.min_quiet_len);
		write_reg(REG_MIN_SPEECH, {1'($urandom), c.min_talk_len});
		write_reg(REG_MAX_SPEECH, c.max_talk_len);
		write_reg(REG_SPLIT_SIL, c.split_silence_samples);
		write_reg(REG_SPARE_B, $urandom);
		cfg_valid <= 1'b0;
	endtask

	function automatic cfg_t make_settings(int unsigned thr, int unsigned win,
		logic [31:0] min_sil, logic [31:0] min_speech, logic [31:0] max_speech,
		logic [31:0] split_sil);
		cfg_t c;
		c.speech_threshold      = thr[PROB_BITS-1:0];
		c.window_samples        = win[WIN_BITS-1:0];
		c.min_quiet_len         = min_sil;
		c.min_talk_len          = min_speech[30:0];
		c.max_talk_len          = max_speech;
		c.split_silence_samples = split_sil;
		return c;
	endfunction

	// A length of a few windows, sometimes zero or all ones
	function automatic logic [31:0] random_span(int unsigned win, int unsigned most);
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return win * $urandom_range(0, most) + $urandom_range(0, win - 1);
		endcase
	endfunction

	function automatic cfg_t random_settings();
		int unsigned thr;
		int unsigned win;
		case ($urandom_range(7))
			0: thr = PROB_MAX;
			1: thr = $urandom_range(0, NEAR_BAND);
			default: thr = $urandom_range(160, 1000);
		endcase
		case ($urandom_range(5))
			0: win = 1;
			1: win = 4096;
			default: win = $urandom_range(1, 4096);
		endcase
		return make_settings(thr, win, random_span(win, 6), random_span(win, 10),
			($urandom_range(2) == 0) ? 32'hFFFF_FFFF : random_span(win, 24),
			random_span(win, 4));
	endfunction

	// Probability levels in each band; where a band is empty any value is used
	function automatic logic [PROB_BITS-1:0] speech_level(int unsigned thr);
		return PROB_BITS'($urandom_range(thr, PROB_MAX));
	endfunction

	function automatic logic [PROB_BITS-1:0] quiet_level(int unsigned thr);
		if (thr > NEAR_BAND)
			return PROB_BITS'($urandom_range(0, thr - NEAR_BAND - 1));
		return PROB_BITS'($urandom_range(0, PROB_MAX));
	endfunction

	function automatic logic [PROB_BITS-1:0] near_level(int unsigned thr);
		if (thr == 0)
			return PROB_BITS'($urandom_range(0, PROB_MAX));
		return PROB_BITS'($urandom_range((thr > NEAR_BAND) ? thr - NEAR_BAND : 0, thr - 1));
	endfunction

	// Runs of speech and silence with some near, noise and finish words
	task automatic run_traffic(input cfg_t c, input int unsigned items);
		int unsigned sent;
		int unsigned len;
		int unsigned kind;
		int unsigned thr;
		thr = c.speech_threshold;
		sent = 0;
		while (sent < items) begin
			kind = $urandom_range(99);
			len = $urandom_range(1, 10);
			if (kind >= 95) begin
				send_finish(($urandom_range(3) == 0) ? OUT_BITS'(0) : OUT_BITS'($urandom));
				sent++;
			end else begin
				for (int i = 0; i < len; i++) begin
					if (kind < 40)
						send_window(speech_level(thr));
					else if (kind < 80)
						send_window(quiet_level(thr));
					else if (kind < 88)
						send_window(near_level(thr));
					else
						send_window(PROB_BITS'($urandom_range(0, PROB_MAX)));
				end
				sent += len;
			end
		end
	endtask

	// Timeout
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_speech_segment_tracker failed");
		$finish;
	end

	initial begin
		cfg_t plan;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: finish with nothing open, band edges, flush, empty audio
		send_finish(OUT_BITS'(0));
		send_window(PROB_BITS'(512));
		send_window(PROB_BITS'(512 - NEAR_BAND));
		send_window(PROB_BITS'(512 - NEAR_BAND - 1));
		send_window(PROB_BITS'(PROB_MAX));
		send_finish(31'h7FFF_FFFF);
		send_window(PROB_BITS'(PROB_MAX));
		send_finish(OUT_BITS'(0));

		// Top threshold, largest window, zero minimum and split lengths: closes on first silence
		settle();
		load_settings(make_settings(PROB_MAX, 4096, 0, 0, 32'hFFFF_FFFF, 0));
		send_window(PROB_BITS'(PROB_MAX));
		send_window(PROB_BITS'(0));

		// No silence band, zero max length: cut at the current sample
		settle();
		load_settings(make_settings(NEAR_BAND, 4096, 0, 0, 0, 32'hFFFF_FFFF));
		send_window(PROB_BITS'(PROB_MAX));
		send_window(PROB_BITS'(NEAR_BAND - 1));

		// Split at a pause, resuming after speech, then split while still silent
		settle();
		load_settings(make_settings(512, 100, 1000, 0, 450, 150));
		send_finish(OUT_BITS'($urandom));
		send_window(PROB_BITS'(PROB_MAX));
		send_window(PROB_BITS'(0));
		send_window(PROB_BITS'(0));
		send_window(PROB_BITS'(0));
		send_window(PROB_BITS'(PROB_MAX));
		send_window(PROB_BITS'(400));
		send_finish(OUT_BITS'(1000));
		send_window(PROB_BITS'(PROB_MAX));
		send_window(PROB_BITS'(0));
		send_window(PROB_BITS'(0));
		send_window(PROB_BITS'(0));
		send_window(PROB_BITS'(0));
		send_finish(OUT_BITS'(77));

		// Random settings and traffic; stall mix changes every third round
		for (int round = 0; round < CONFIG_ROUNDS; round++) begin
			case (round / 3)
				0: begin
					tx_idle = 17;
					rx_idle <= 87;
				end
				1: begin
					tx_idle = 87;
					rx_idle <= 17;
				end
				default: begin
					tx_idle = 0;
					rx_idle <= 0;
				end
			endcase
			settle();
			plan = random_settings();
			load_settings(plan);
			run_traffic(plan, SEGMENT_ITEMS);
		end

		// Nothing may be left over on the result side
		settle();
		if (fail_count == 0 && empty)
			$display("tb_speech_segment_tracker passed");
		else
			$display("tb_speech_segment_tracker failed");
		$finish;
	end

endmodule

[sim.f]
src/sst_pkg.sv
src/sst_regs.sv
src/sst_queue.sv
src/sst_front.sv
src/sst_back.sv
src/speech_segment_tracker.sv
test/sst_tb_pkg.sv
test/segment_checker.sv
test/tb_speech_segment_tracker.sv
